// ----- hw/rtl/cdq_pkg.sv -----
`default_nettype none
package cdq_pkg;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_LIST   = 2'd2,
		REQ_UNUSED = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	localparam logic END_REAR  = 1'b0;
	localparam logic END_FRONT = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SKIP,
		OP_INS_REAR,
		OP_INS_FRONT,
		OP_REM_REAR,
		OP_REM_FRONT,
		OP_REJ_FULL,
		OP_REJ_EMPTY,
		OP_LIST_REAR,
		OP_LIST_FRONT,
		OP_LIST_STEP
	} op_t;

	typedef enum logic {
		S_IDLE,
		S_LIST
	} ctrl_state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic list_last;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cdq_ctrl.sv -----
`default_nettype none
module cdq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        req_type,
	input  wire logic              which_end,
	input  wire cdq_pkg::dp_stat_t dp_stat,
	output cdq_pkg::cmd_t          cmd
);

	cdq_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd.op   = cdq_pkg::OP_NONE;
		case (state_q)
			cdq_pkg::S_IDLE: begin
				in_ready = dp_stat.out_free;
				if (in_valid && dp_stat.out_free) begin
					case (req_type)
						cdq_pkg::REQ_INSERT: begin
							if (dp_stat.full) begin
								cmd.op = cdq_pkg::OP_REJ_FULL;
							end else if (which_end == cdq_pkg::END_REAR) begin
								cmd.op = cdq_pkg::OP_INS_REAR;
							end else begin
								cmd.op = cdq_pkg::OP_INS_FRONT;
							end
						end
						cdq_pkg::REQ_REMOVE: begin
							if (dp_stat.empty) begin
								cmd.op = cdq_pkg::OP_REJ_EMPTY;
							end else if (which_end == cdq_pkg::END_REAR) begin
								cmd.op = cdq_pkg::OP_REM_REAR;
							end else begin
								cmd.op = cdq_pkg::OP_REM_FRONT;
							end
						end
						cdq_pkg::REQ_LIST: begin
							if (dp_stat.empty) begin
								cmd.op = cdq_pkg::OP_REJ_EMPTY;
							end else begin
								state_d = cdq_pkg::S_LIST;
								if (which_end == cdq_pkg::END_REAR) begin
									cmd.op = cdq_pkg::OP_LIST_REAR;
								end else begin
									cmd.op = cdq_pkg::OP_LIST_FRONT;
								end
							end
						end
						default: begin
							cmd.op = cdq_pkg::OP_SKIP;
						end
					endcase
				end
			end
			cdq_pkg::S_LIST: begin
				if (dp_stat.out_free) begin
					cmd.op = cdq_pkg::OP_LIST_STEP;
					if (dp_stat.list_last) begin
						state_d = cdq_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = cdq_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/cdq_dp.sv -----
`default_nettype none
module cdq_dp #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cdq_pkg::cmd_t      cmd,
	input  wire logic signed [31:0] item_value,
	output cdq_pkg::dp_stat_t       dp_stat,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      elem_value,
	output logic [1:0]              status,
	output logic                    last_flag
);

	localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rd_data_q;
	logic [PW-1:0] rear_q, front_q, lp_q, cnt_q;
	logic          dir_q;
	logic          out_valid_q;

	logic [PW-1:0] rear_inc, rear_dec, front_inc, front_dec, lp_inc, lp_dec, lp_next;
	logic [PW-1:0] rd_addr, wr_addr, count;
	logic [PW:0]   diff;
	logic          wr_en, load;
	logic [31:0]   res_elem;
	logic [1:0]    res_stat;

	function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
		ring_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p);
		ring_dec = (p == '0) ? LAST_IDX : p - 1'b1;
	endfunction

	assign rear_inc  = ring_inc(rear_q);
	assign rear_dec  = ring_dec(rear_q);
	assign front_inc = ring_inc(front_q);
	assign front_dec = ring_dec(front_q);
	assign lp_inc    = ring_inc(lp_q);
	assign lp_dec    = ring_dec(lp_q);
	assign lp_next   = (dir_q == cdq_pkg::END_REAR) ? lp_dec : lp_inc;

	always_comb begin
		if (rear_q >= front_q) begin
			diff = {1'b0, rear_q} - {1'b0, front_q};
		end else begin
			diff = {1'b0, rear_q} + DEPTH_W - {1'b0, front_q};
		end
	end
	assign count = diff[PW-1:0];

	assign dp_stat.full      = (rear_inc == front_q);
	assign dp_stat.empty     = (rear_q == front_q);
	assign dp_stat.list_last = (cnt_q == PW'(1));
	assign dp_stat.out_free  = !out_valid_q || out_ready;

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = rear_inc;
		rd_addr  = lp_q;
		load     = 1'b1;
		res_elem = '0;
		res_stat = cdq_pkg::STAT_OK;
		case (cmd.op)
			cdq_pkg::OP_INS_REAR: begin
				wr_en = 1'b1;
			end
			cdq_pkg::OP_INS_FRONT: begin
				wr_en   = 1'b1;
				wr_addr = front_q;
			end
			cdq_pkg::OP_REJ_FULL: begin
				res_stat = cdq_pkg::STAT_FULL;
			end
			cdq_pkg::OP_REJ_EMPTY: begin
				res_stat = cdq_pkg::STAT_EMPTY;
			end
			cdq_pkg::OP_LIST_REAR: begin
				rd_addr = rear_q;
				load    = 1'b0;
			end
			cdq_pkg::OP_LIST_FRONT: begin
				rd_addr = front_inc;
				load    = 1'b0;
			end
			cdq_pkg::OP_LIST_STEP: begin
				rd_addr  = lp_next;
				res_elem = rd_data_q;
			end
			cdq_pkg::OP_REM_REAR, cdq_pkg::OP_REM_FRONT: begin
				load = 1'b1;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= item_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rear_q      <= '0;
			front_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				cdq_pkg::OP_INS_REAR:  rear_q  <= rear_inc;
				cdq_pkg::OP_INS_FRONT: front_q <= front_dec;
				cdq_pkg::OP_REM_REAR:  rear_q  <= rear_dec;
				cdq_pkg::OP_REM_FRONT: front_q <= front_inc;
				default: begin
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// list walk pointer and remaining count
	always_ff @(posedge clk) begin
		case (cmd.op)
			cdq_pkg::OP_LIST_REAR: begin
				lp_q  <= rear_q;
				cnt_q <= count;
				dir_q <= cdq_pkg::END_REAR;
			end
			cdq_pkg::OP_LIST_FRONT: begin
				lp_q  <= front_inc;
				cnt_q <= count;
				dir_q <= cdq_pkg::END_FRONT;
			end
			cdq_pkg::OP_LIST_STEP: begin
				lp_q  <= lp_next;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (load) begin
			elem_value <= res_elem;
			status     <= res_stat;
			last_flag  <= (cmd.op != cdq_pkg::OP_LIST_STEP) || dp_stat.list_last;
		end
	end

	assign out_valid = out_valid_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped while stalled");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rear_q <= LAST_IDX) && (front_q <= LAST_IDX))
		else $error("pointer out of ring");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == cdq_pkg::OP_INS_REAR || cmd.op == cdq_pkg::OP_INS_FRONT) |-> !dp_stat.full)
		else $error("insert into full ring");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == cdq_pkg::OP_LIST_STEP) |-> (cnt_q != '0))
		else $error("list step with nothing left");

endmodule
`default_nettype wire

// ----- hw/rtl/circular_deque_core.sv -----
`default_nettype none
// channel   | direction | handshake            | payload
// request   | in        | in_valid / in_ready  | req_type, which_end, item_value
// result    | out       | out_valid / out_ready| elem_value, status, last_flag
//
// insert, remove and rejected requests give one result each
// a list request first primes the registered read port, then gives one result per
// stored element per cycle while the result register is not stalled; the next
// request waits for the walk to end
// reset clears the rear and front pointers; slot contents are undefined until written
// a stalled result register holds and stops both the walk and new requests
module circular_deque_core #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic               which_end,
	input  wire logic signed [31:0] item_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      elem_value,
	output logic [1:0]              status,
	output logic                    last_flag
);

	cdq_pkg::cmd_t     cmd;
	cdq_pkg::dp_stat_t dp_stat;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.which_end (which_end),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	cdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item_value (item_value),
		.dp_stat    (dp_stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.elem_value (elem_value),
		.status     (status),
		.last_flag  (last_flag)
	);

endmodule
`default_nettype wire
